// ----- sv/pcws_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM capture statistics package
// Shared codes, reset values and output clamping helpers for the PWM input
// capture block with windowed period statistics.
// ----------------------------------------------------------------------------
package pcws_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_RISE   = 2'd0;
  localparam logic [1:0] OP_FALL   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // Configuration register indexes.
  localparam int unsigned    CFG_INDEX_BITS   = 2;
  localparam logic [1:0]     REG_LONG_WINDOW  = 2'd0;
  localparam logic [1:0]     REG_SHORT_WINDOW = 2'd1;
  localparam logic [1:0]     REG_PRESENCE_TO  = 2'd2;

  // Register reset values.
  localparam logic [31:0] LONG_WINDOW_RST  = 32'd60000000;
  localparam logic [31:0] SHORT_WINDOW_RST = 32'd10000000;
  localparam logic [31:0] PRESENCE_TO_RST  = 32'd2000000;

  // Display limits.
  localparam logic [31:0] WIDTH_HI  = 32'd2399;
  localparam logic [31:0] WIDTH_LO  = 32'd199;
  localparam logic [31:0] PERIOD_HI = 32'd29999;
  localparam logic [31:0] PERIOD_LO = 32'd999;

  // Clamp a pulse width to the display range; an absent signal reads as the
  // low limit unless the width is above the high limit.
  function automatic logic [11:0] clamp_width(input logic [31:0] w, input logic present);
    logic [31:0] r;
    if (w > WIDTH_HI) begin
      r = WIDTH_HI;
    end else if (w < WIDTH_LO || !present) begin
      r = WIDTH_LO;
    end else begin
      r = w;
    end
    return r[11:0];
  endfunction

  // Clamp a period to the display range; an absent signal reads as the top.
  function automatic logic [14:0] clamp_period(input logic [31:0] p, input logic present);
    logic [31:0] r;
    if (p > PERIOD_HI || !present) begin
      r = PERIOD_HI;
    end else if (p < PERIOD_LO) begin
      r = PERIOD_LO;
    end else begin
      r = p;
    end
    return r[14:0];
  endfunction

endpackage

// ----- sv/pcws_ram.sv -----
// ----------------------------------------------------------------------------
// Generic sample RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the word being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pcws_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcws_div #(
  parameter int unsigned DVD_BITS = 39,
  parameter int unsigned DVS_BITS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                done,
  output logic [DVD_BITS-1:0] quotient
);

  localparam int unsigned STEP_BITS = $clog2(DVD_BITS + 1);

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [DVS_BITS-1:0]  rem;
  logic [DVS_BITS-1:0]  dvs;
  logic [DVD_BITS-1:0]  quo;
  logic [DVS_BITS:0]    trial;
  logic [DVS_BITS:0]    diff;
  logic                 fits;

  // One shift and trial subtract per cycle.
  assign trial = {rem, quo[DVD_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_BITS'(DVD_BITS);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
      quo <= {quo[DVD_BITS-2:0], fits};
    end
  end

endmodule

// ----- sv/pwm_capture_window_stats.sv -----
// ----------------------------------------------------------------------------
// PWM capture window statistics
// Measures period and pulse width of a servo PWM input from timestamped
// edges and reports presence, clamped values and windowed period statistics.
// ----------------------------------------------------------------------------
// Edge requests update the measurements at the accepting edge; in_ready stays high.
// A report holds in_ready low through the log, evict, scan, divide and load steps and
// any output stall. Eviction pops the samples older than the long window once it has
// elapsed, the scan reads every sample left, and the divide runs only when the short
// window holds samples.
// Synchronous reset clears all measurements, empties the ring and loads the defaults.
module pwm_capture_window_stats #(
  parameter int unsigned SAMPLE_DEPTH = 64,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Item input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             op,
  input  logic [TIME_BITS-1:0]                   time_us,
  // Result output channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [11:0]                            pulse_width_us,
  output logic [14:0]                            last_period_us,
  output logic                                   signal_present,
  output logic [14:0]                            min_period_us,
  output logic [14:0]                            max_period_us,
  output logic [31:0]                            avg_period_us,
  output logic [$clog2(SAMPLE_DEPTH+1)-1:0]      short_count,
  // Configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pcws_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [31:0]                            cfg_data
);

  import pcws_pkg::*;

  localparam int unsigned ADDR_BITS = $clog2(SAMPLE_DEPTH);
  localparam int unsigned SLOT_BITS = ADDR_BITS + 1;
  localparam int unsigned CNT_BITS  = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned SUM_BITS  = 32 + CNT_BITS;
  localparam int unsigned WORD_BITS = TIME_BITS + 32;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOG    = 6'b000010,
    S_EVICT  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  // Time difference modulo the timestamp width, saturated to 32 bits.
  function automatic logic [31:0] sat_diff(input logic [TIME_BITS-1:0] now,
                                           input logic [TIME_BITS-1:0] then_t);
    logic [TIME_BITS-1:0] d;
    d = now - then_t;
    if (d > TIME_BITS'(32'hFFFF_FFFF)) begin
      return 32'hFFFF_FFFF;
    end
    return d[31:0];
  endfunction

  // Ring pointer increment with wrap at the depth.
  function automatic logic [ADDR_BITS-1:0] wrap_inc(input logic [ADDR_BITS-1:0] p);
    if (p == ADDR_BITS'(SAMPLE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  state_t state;

  // Configuration registers.
  logic [31:0] long_window_us;
  logic [31:0] short_window_us;
  logic [31:0] presence_timeout_us;

  // Measurement state.
  logic                 rise_seen;
  logic [TIME_BITS-1:0] last_rise_time;
  logic [TIME_BITS-1:0] last_edge_time;
  logic [31:0]          measured_period;
  logic [31:0]          measured_width;
  logic [31:0]          last_logged_period;
  logic [ADDR_BITS-1:0] ring_head;
  logic [CNT_BITS-1:0]  ring_count;

  // Report working registers.
  logic [TIME_BITS-1:0] now_time;
  logic                 present;
  logic                 ev_en;
  logic [TIME_BITS-1:0] ev_start;
  logic                 ev_wait;
  logic                 all_short;
  logic [TIME_BITS-1:0] short_start;
  logic [ADDR_BITS-1:0] rptr;
  logic [CNT_BITS-1:0]  issued;
  logic                 pend;
  logic                 first;
  logic [31:0]          mn;
  logic [31:0]          mx;
  logic [SUM_BITS-1:0]  sum;
  logic [CNT_BITS-1:0]  sh_cnt;

  // Combinational helpers.
  logic                 in_fire;
  logic                 out_load;
  logic [TIME_BITS-1:0] edge_age;
  logic                 log_take;
  logic                 ring_full;
  logic [ADDR_BITS-1:0] head_adj;
  logic [CNT_BITS-1:0]  count_adj;
  logic [SLOT_BITS-1:0] slot_sum;
  logic [ADDR_BITS-1:0] slot;
  logic                 scan_end;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_BITS-1:0]  div_quo;

  // RAM ports.
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [31:0]          rd_period;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_FINISH) && (!out_valid || out_ready);

  // Logging decision and ring slot for the new sample.
  assign edge_age  = now_time - last_edge_time;
  assign log_take  = (measured_period != 32'd0) && (measured_period != last_logged_period);
  assign ring_full = (ring_count >= CNT_BITS'(SAMPLE_DEPTH));
  assign head_adj  = ring_full ? wrap_inc(ring_head) : ring_head;
  assign count_adj = ring_full ? CNT_BITS'(SAMPLE_DEPTH - 1) : ring_count;
  assign slot_sum  = SLOT_BITS'(head_adj) + SLOT_BITS'(count_adj);
  assign slot      = (slot_sum >= SLOT_BITS'(SAMPLE_DEPTH)) ?
                     ADDR_BITS'(slot_sum - SLOT_BITS'(SAMPLE_DEPTH)) :
                     ADDR_BITS'(slot_sum);

  // Scan completion and divider launch.
  assign scan_end  = (state == S_SCAN) && (issued == ring_count) && !pend;
  assign div_start = scan_end && (sh_cnt != '0);

  // Sample memory: each word holds a timestamp above a period.
  assign ram_we    = (state == S_LOG) && log_take;
  assign ram_wdata = {now_time, measured_period};
  assign ram_raddr = (state == S_SCAN) ? rptr : ring_head;
  assign rd_time   = ram_rdata[WORD_BITS-1:32];
  assign rd_period = ram_rdata[31:0];

  pcws_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcws_div #(
    .DVD_BITS (SUM_BITS),
    .DVS_BITS (CNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (sh_cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_window_us      <= LONG_WINDOW_RST;
      short_window_us     <= SHORT_WINDOW_RST;
      presence_timeout_us <= PRESENCE_TO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LONG_WINDOW:  long_window_us      <= cfg_data;
        REG_SHORT_WINDOW: short_window_us     <= cfg_data;
        REG_PRESENCE_TO:  presence_timeout_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and measurement state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      rise_seen          <= 1'b0;
      last_rise_time     <= '0;
      last_edge_time     <= '0;
      measured_period    <= '0;
      measured_width     <= '0;
      last_logged_period <= '0;
      ring_head          <= '0;
      ring_count         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (op)
              OP_RISE: begin
                if (rise_seen) begin
                  measured_period <= sat_diff(time_us, last_rise_time);
                end
                last_rise_time <= time_us;
                last_edge_time <= time_us;
                rise_seen      <= 1'b1;
              end
              OP_FALL: begin
                if (rise_seen) begin
                  measured_width <= sat_diff(time_us, last_rise_time);
                  last_edge_time <= time_us;
                end
              end
              OP_REPORT: begin
                state <= S_LOG;
              end
              default: ;
            endcase
          end
        end
        S_LOG: begin
          // Log a changed period, dropping the oldest sample when full.
          if (log_take) begin
            ring_head          <= head_adj;
            ring_count         <= count_adj + 1'b1;
            last_logged_period <= measured_period;
          end
          state <= S_EVICT;
        end
        S_EVICT: begin
          // Pop samples older than the long window, one read per pop.
          if (!ev_en || ring_count == '0) begin
            state <= S_SCAN;
          end else if (!ev_wait && rd_time < ev_start) begin
            ring_head  <= wrap_inc(ring_head);
            ring_count <= ring_count - 1'b1;
          end else if (!ev_wait) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= (sh_cnt == '0) ? S_FINISH : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Report working registers; they need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_time <= time_us;
    end

    // Window bounds and presence are settled once per report.
    if (state == S_LOG) begin
      present     <= rise_seen && (edge_age < TIME_BITS'(presence_timeout_us));
      ev_en       <= now_time >= TIME_BITS'(long_window_us);
      ev_start    <= now_time - TIME_BITS'(long_window_us);
      all_short   <= now_time < TIME_BITS'(short_window_us);
      short_start <= now_time - TIME_BITS'(short_window_us);
      ev_wait     <= 1'b1;
    end

    // Each pop waits for the new head's registered read data.
    if (state == S_EVICT) begin
      ev_wait <= !ev_wait ? (rd_time < ev_start) : 1'b0;
      rptr    <= ring_head;
      issued  <= '0;
      pend    <= 1'b0;
      first   <= 1'b1;
      mn      <= '0;
      mx      <= '0;
      sum     <= '0;
      sh_cnt  <= '0;
    end

    // Walk the ring: issue one read per cycle and fold the previous one.
    if (state == S_SCAN) begin
      if (issued != ring_count) begin
        rptr   <= wrap_inc(rptr);
        issued <= issued + 1'b1;
        pend   <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
      if (pend) begin
        first <= 1'b0;
        if (first || rd_period < mn) begin
          mn <= rd_period;
        end
        if (first || rd_period > mx) begin
          mx <= rd_period;
        end
        if (all_short || rd_time >= short_start) begin
          sum    <= sum + SUM_BITS'(rd_period);
          sh_cnt <= sh_cnt + 1'b1;
        end
      end
    end
  end

  // Output register; a finished result may wait while the block takes edges.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pulse_width_us <= clamp_width(measured_width, present);
      last_period_us <= clamp_period(measured_period, present);
      signal_present <= present;
      min_period_us  <= clamp_period(mn, present);
      max_period_us  <= clamp_period(mx, present);
      avg_period_us  <= (sh_cnt == '0) ? 32'd0 : div_quo[31:0];
      short_count    <= sh_cnt;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PWM capture window statistics testbench
// Drives timestamped edge and report requests into the capture block. A
// directed table covers the corner cases first, then random pulse trains run
// under several window and timeout settings. Every report is checked field by
// field against a typed table result or a behavioral predictor in this bench.
// ----------------------------------------------------------------------------
module testbench;
  import pcws_pkg::*;

  localparam int unsigned RING_DEPTH   = 64;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_PRINTED  = 200;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [11:0] width;
    logic [14:0] period;
    logic        present;
    logic [14:0] min_p;
    logic [14:0] max_p;
    logic [31:0] avg;
    logic [6:0]  cnt;
  } capture_report_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [47:0]     t;
    logic            typed;
    capture_report_t res;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] long_win;
    logic [31:0] short_win;
    logic [31:0] timeout;
    logic [47:0] start;
    logic [15:0] items;
  } phase_t;

  localparam capture_report_t UNTYPED       = '0;
  localparam capture_report_t ABSENT_REPORT =
    '{12'd199, 15'd29999, 1'b0, 15'd29999, 15'd29999, 32'd0, 7'd0};
  localparam capture_report_t FIRST_RISE_REPORT =
    '{12'd199, 15'd999, 1'b1, 15'd999, 15'd999, 32'd0, 7'd0};

  // Directed requests: ordering before the first rise, short and long pulses,
  // zero period, timeout, time extremes and wrap, ignored op code.
  localparam stim_row_t DIRECTED [26] = '{
    '{OP_REPORT, 48'd0,                1'b1, ABSENT_REPORT},
    '{OP_FALL,   48'd5,                1'b0, UNTYPED},
    '{OP_REPORT, 48'd10,               1'b1, ABSENT_REPORT},
    '{OP_RISE,   48'd100,              1'b0, UNTYPED},
    '{OP_REPORT, 48'd200,              1'b1, FIRST_RISE_REPORT},
    '{OP_FALL,   48'd1600,             1'b0, UNTYPED},
    '{OP_RISE,   48'd20100,            1'b0, UNTYPED},
    '{OP_REPORT, 48'd20200,            1'b0, UNTYPED},
    '{OP_FALL,   48'd20150,            1'b0, UNTYPED},
    '{OP_RISE,   48'd20600,            1'b0, UNTYPED},
    '{OP_REPORT, 48'd20700,            1'b0, UNTYPED},
    '{OP_RISE,   48'd20600,            1'b0, UNTYPED},
    '{OP_REPORT, 48'd20800,            1'b0, UNTYPED},
    '{OP_FALL,   48'd23600,            1'b0, UNTYPED},
    '{OP_RISE,   48'd70600,            1'b0, UNTYPED},
    '{OP_REPORT, 48'd70700,            1'b0, UNTYPED},
    '{OP_UNUSED, 48'hFFFF_FFFF_FFFF,   1'b0, UNTYPED},
    '{OP_REPORT, 48'd2100000,          1'b0, UNTYPED},
    '{OP_RISE,   48'hFFFF_FFFF_FFFF,   1'b0, UNTYPED},
    '{OP_REPORT, 48'hFFFF_FFFF_FFFF,   1'b0, UNTYPED},
    '{OP_RISE,   48'd0,                1'b0, UNTYPED},
    '{OP_FALL,   48'h0000_0000_0500,   1'b0, UNTYPED},
    '{OP_REPORT, 48'h0000_0000_0800,   1'b0, UNTYPED},
    '{OP_REPORT, 48'h0000_0000_0100,   1'b0, UNTYPED},
    '{OP_FALL,   48'h8000_0000_0000,   1'b0, UNTYPED},
    '{OP_REPORT, 48'h8000_0000_0000,   1'b0, UNTYPED}
  };

  // Window and timeout settings for the random phases, extremes included.
  localparam phase_t PHASES [6] = '{
    '{32'd200000,    32'd60000,        32'd25000,       48'd1000,          16'd70},
    '{32'd1,         32'd1,            32'd1,           48'd90000000,      16'd70},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF,    32'hFFFF_FFFF,   48'd100000000,     16'd260},
    '{32'd0,         32'd0,            32'd0,           48'd200000000,     16'd70},
    '{LONG_WINDOW_RST, SHORT_WINDOW_RST, PRESENCE_TO_RST, 48'hFFFF_FFF0_0000, 16'd70},
    '{32'd300000,    32'd100000,       32'd40000,       48'd5000,          16'd70}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_RISE;
  logic [47:0] time_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] pulse_width_us;
  logic [14:0] last_period_us;
  logic        signal_present;
  logic [14:0] min_period_us;
  logic [14:0] max_period_us;
  logic [31:0] avg_period_us;
  logic [6:0]  short_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_LONG_WINDOW;
  logic [31:0] cfg_data = '0;

  // Typed expectation that travels with the request currently offered.
  logic            item_typed = 1'b0;
  capture_report_t item_typed_res = '0;

  capture_report_t reports_due[$];
  int unsigned     errors = 0;
  int unsigned     reports_seen = 0;
  int unsigned     items_sent = 0;
  int unsigned     quiet_cycles = 0;
  bit              calm = 1'b0;
  logic [47:0]     stamp = '0;

  // Predictor state and its copy of the registers.
  bit          rise_seen = 1'b0;
  logic [47:0] last_rise_us = '0;
  logic [47:0] last_edge_us = '0;
  logic [31:0] period_meas = '0;
  logic [31:0] width_meas = '0;
  logic [31:0] logged_period = '0;
  logic [47:0] ring_stamp [RING_DEPTH];
  logic [31:0] ring_period [RING_DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_fill = 0;
  logic [31:0] win_long = LONG_WINDOW_RST;
  logic [31:0] win_short = SHORT_WINDOW_RST;
  logic [31:0] presence_to = PRESENCE_TO_RST;

  pwm_capture_window_stats dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .time_us        (time_us),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pulse_width_us (pulse_width_us),
    .last_period_us (last_period_us),
    .signal_present (signal_present),
    .min_period_us  (min_period_us),
    .max_period_us  (max_period_us),
    .avg_period_us  (avg_period_us),
    .short_count    (short_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Time difference, wrapped to the timestamp width and saturated to 32 bits.
  function automatic logic [31:0] elapsed_sat(input logic [47:0] now, input logic [47:0] then_us);
    logic [47:0] d;
    d = now - then_us;
    return (d > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  function automatic logic [14:0] clip_period(input logic [31:0] p, input bit live);
    logic [31:0] r;
    r = (p > PERIOD_HI || !live) ? PERIOD_HI : ((p < PERIOD_LO) ? PERIOD_LO : p);
    return r[14:0];
  endfunction

  function automatic logic [11:0] clip_width(input logic [31:0] w, input bit live);
    logic [31:0] r;
    r = (w > WIDTH_HI) ? WIDTH_HI : ((w < WIDTH_LO || !live) ? WIDTH_LO : w);
    return r[11:0];
  endfunction

  // Advance the predicted capture state by one request; a report request
  // also produces the expected statistics.
  task automatic predict_capture(input logic [1:0] code, input logic [47:0] now,
                                 output bit fires, output capture_report_t rep);
    bit          live;
    bit          all_short;
    logic [47:0] start;
    logic [47:0] short_start;
    logic [31:0] mn;
    logic [31:0] mx;
    logic [31:0] p;
    logic [63:0] sum;
    int unsigned cnt;
    int unsigned idx;
    fires = 1'b0;
    rep = '0;
    case (code)
      OP_RISE: begin
        if (rise_seen) period_meas = elapsed_sat(now, last_rise_us);
        last_rise_us = now;
        last_edge_us = now;
        rise_seen = 1'b1;
      end
      OP_FALL: begin
        if (rise_seen) begin
          width_meas = elapsed_sat(now, last_rise_us);
          last_edge_us = now;
        end
      end
      OP_REPORT: begin
        fires = 1'b1;
        live = rise_seen && ((now - last_edge_us) < {16'd0, presence_to});
        // Log a changed nonzero period, dropping the oldest sample when full.
        if (period_meas != 0 && period_meas != logged_period) begin
          if (ring_fill >= RING_DEPTH) begin
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_fill = RING_DEPTH - 1;
          end
          idx = (ring_head + ring_fill) % RING_DEPTH;
          ring_stamp[idx] = now;
          ring_period[idx] = period_meas;
          ring_fill++;
          logged_period = period_meas;
        end
        // Evict samples that fell out of the long window.
        if (now >= {16'd0, win_long}) begin
          start = now - {16'd0, win_long};
          while (ring_fill > 0 && ring_stamp[ring_head] < start) begin
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_fill--;
          end
        end
        // Before the short window has elapsed every stored sample counts.
        all_short = now < {16'd0, win_short};
        short_start = all_short ? '0 : now - {16'd0, win_short};
        mn = '0;
        mx = '0;
        sum = '0;
        cnt = 0;
        for (int k = 0; k < ring_fill; k++) begin
          idx = (ring_head + k) % RING_DEPTH;
          p = ring_period[idx];
          if (k == 0 || p < mn) mn = p;
          if (k == 0 || p > mx) mx = p;
          if (all_short || ring_stamp[idx] >= short_start) begin
            sum += p;
            cnt++;
          end
        end
        rep.width = clip_width(width_meas, live);
        rep.period = clip_period(period_meas, live);
        rep.present = live;
        rep.min_p = clip_period(mn, live);
        rep.max_p = clip_period(mx, live);
        rep.avg = (cnt != 0) ? 32'(sum / cnt) : '0;
        rep.cnt = 7'(cnt);
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_error(input string msg);
    if (errors < MAX_PRINTED) $display("%0t ns: MISMATCH %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_report(input capture_report_t got, input capture_report_t want);
    if (got.width !== want.width)
      flag_error($sformatf("report %0d pulse width %0d, expected %0d",
                           reports_seen, got.width, want.width));
    if (got.period !== want.period)
      flag_error($sformatf("report %0d period %0d, expected %0d",
                           reports_seen, got.period, want.period));
    if (got.present !== want.present)
      flag_error($sformatf("report %0d presence %0d, expected %0d",
                           reports_seen, got.present, want.present));
    if (got.min_p !== want.min_p)
      flag_error($sformatf("report %0d min period %0d, expected %0d",
                           reports_seen, got.min_p, want.min_p));
    if (got.max_p !== want.max_p)
      flag_error($sformatf("report %0d max period %0d, expected %0d",
                           reports_seen, got.max_p, want.max_p));
    if (got.avg !== want.avg)
      flag_error($sformatf("report %0d avg period %0d, expected %0d",
                           reports_seen, got.avg, want.avg));
    if (got.cnt !== want.cnt)
      flag_error($sformatf("report %0d short count %0d, expected %0d",
                           reports_seen, got.cnt, want.cnt));
  endtask

  // Follow every accepted request on all three channels.
  always @(posedge clk) begin : monitor
    capture_report_t want;
    capture_report_t got;
    bit              fires;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LONG_WINDOW:  win_long = cfg_data;
          REG_SHORT_WINDOW: win_short = cfg_data;
          REG_PRESENCE_TO:  presence_to = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        predict_capture(op, time_us, fires, want);
        if (fires) reports_due.push_back(item_typed ? item_typed_res : want);
      end
      if (out_valid && out_ready) begin
        got = '{pulse_width_us, last_period_us, signal_present, min_period_us,
                max_period_us, avg_period_us, short_count};
        if (reports_due.size() == 0) begin
          flag_error($sformatf("report %0d arrived with none expected", reports_seen));
        end else begin
          check_report(got, reports_due[0]);
          reports_due.delete(0);
        end
        reports_seen++;
      end
    end
  end

  // Watchdog on cycles in which no request of any kind is accepted.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Result side: stall a random number of cycles before taking each report.
  initial begin : result_sink
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one request after a random gap and hold it until it is accepted.
  task automatic send_item(input logic [1:0] code, input logic [47:0] at,
                           input bit typed, input capture_report_t typed_res);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    time_us <= at;
    item_typed <= typed;
    item_typed_res <= typed_res;
    do @(posedge clk); while (!in_ready);
    if (code != OP_UNUSED) items_sent++;
  endtask

  // Register write; the request stays up so back-to-back writes need no gap,
  // and the caller drops it after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait for every outstanding report, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] draw_period();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1200);
    if (r == 1) return $urandom_range(28000, 80000);
    return $urandom_range(2500, 22000);
  endfunction

  function automatic logic [31:0] draw_width();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 300);
    if (r == 1) return $urandom_range(2300, 6000);
    return $urandom_range(500, 2500);
  endfunction

  // Random pulse trains with reports, dropouts, out-of-order edges and noise.
  task automatic run_phase(input int unsigned target);
    int unsigned r;
    logic [1:0]  noise_op;
    items_sent = 0;
    while (items_sent < target) begin
      if ($urandom_range(0, 24) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        stamp = stamp + 48'(draw_period());
        send_item(OP_RISE, stamp, 1'b0, UNTYPED);
        if ($urandom_range(0, 3) != 0)
          send_item(OP_FALL, stamp + 48'(draw_width()), 1'b0, UNTYPED);
        if ($urandom_range(0, 4) != 0)
          send_item(OP_REPORT, stamp + 48'($urandom_range(0, 4000)), 1'b0, UNTYPED);
      end else if (r < 80) begin
        // Signal dropout of random length, then a report.
        stamp = stamp + 48'($urandom_range(0, 3000000));
        send_item(OP_REPORT, stamp, 1'b0, UNTYPED);
      end else if (r < 90) begin
        // Edge stamped earlier than the running time.
        send_item(($urandom_range(0, 1) != 0) ? OP_FALL : OP_RISE,
                  stamp - 48'($urandom_range(0, 50000)), 1'b0, UNTYPED);
      end else begin
        case ($urandom_range(0, 2))
          0: noise_op = OP_RISE;
          1: noise_op = OP_FALL;
          default: noise_op = OP_UNUSED;
        endcase
        send_item(noise_op, {16'($urandom), 32'($urandom)}, 1'b0, UNTYPED);
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].op, DIRECTED[i].t, DIRECTED[i].typed, DIRECTED[i].res);
    drain();

    foreach (PHASES[p]) begin
      write_reg(REG_LONG_WINDOW, PHASES[p].long_win);
      write_reg(REG_SHORT_WINDOW, PHASES[p].short_win);
      write_reg(REG_PRESENCE_TO, PHASES[p].timeout);
      write_reg(REG_UNUSED, $urandom);
      cfg_valid <= 1'b0;
      stamp = PHASES[p].start;
      run_phase(32'(PHASES[p].items));
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
